// ===== sv/scpu_pkg.sv =====
// shared types, constants and address decode for the subleq cpu
`default_nettype none
package scpu_pkg;

	localparam int ADDR_W      = 8;
	localparam int DATA_W      = 8;
	localparam int MEM_DEPTH   = 256;
	localparam int DIGIT_COUNT = 6;
	localparam int PAIR_COUNT  = DIGIT_COUNT / 2;

	localparam logic [ADDR_W-1:0] START_RESET = 8'd10;
	localparam logic [ADDR_W-1:0] DIGIT_FIRST = 8'd1;
	localparam logic [ADDR_W-1:0] DIGIT_LAST  = 8'd6;
	localparam logic [ADDR_W-1:0] PAIR_FIRST  = 8'd7;
	localparam logic [ADDR_W-1:0] PAIR_LAST   = 8'd9;
	localparam logic [ADDR_W-1:0] PC_STEP     = 8'd3;

	// host action codes
	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_START = 2'd2,
		ACT_STEP  = 2'd3
	} action_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_FETCH_A,
		ST_FETCH_B,
		ST_FETCH_C,
		ST_LOAD_A,
		ST_LOAD_B
	} state_t;

	// command word
	typedef struct packed {
		action_t             action;
		logic [ADDR_W-1:0]   address;
		logic [DATA_W-1:0]   write_data;
	} cmd_word_t;

	// result word
	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [ADDR_W-1:0] program_counter;
		logic              halted;
		logic [DATA_W-1:0] digit_0;
		logic [DATA_W-1:0] digit_1;
		logic [DATA_W-1:0] digit_2;
		logic [DATA_W-1:0] digit_3;
		logic [DATA_W-1:0] digit_4;
		logic [DATA_W-1:0] digit_5;
	} res_word_t;

	// write port into the display registers
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} disp_wr_t;

	// true for addresses that reach the display instead of main memory
	function automatic logic is_mapped(input logic [ADDR_W-1:0] addr);
		return addr inside {[DIGIT_FIRST:PAIR_LAST]};
	endfunction

endpackage
`default_nettype wire

// ===== sv/scpu_ram.sv =====
// generic single-port ram with registered read
`default_nettype none
module scpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and read-first registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

// ===== sv/scpu_disp.sv =====
// six display digit registers with single and packed-pair mapped access
`default_nettype none
module scpu_disp import scpu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire disp_wr_t          wr,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	output logic      [DATA_W-1:0] digit [DIGIT_COUNT]
);

	logic [DATA_W-1:0] digit_q [DIGIT_COUNT];

	// single digit writes keep the whole byte, pair writes split nibbles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				digit_q[i] <= '0;
			end
		end else if (wr.we) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				if (wr.addr == DIGIT_FIRST + ADDR_W'(i)) begin
					digit_q[i] <= wr.data;
				end
			end
			for (int k = 0; k < PAIR_COUNT; k++) begin
				if (wr.addr == PAIR_FIRST + ADDR_W'(k)) begin
					digit_q[2*k]   <= {4'h0, wr.data[3:0]};
					digit_q[2*k+1] <= {4'h0, wr.data[7:4]};
				end
			end
		end
	end

	// mapped read: low nibble of one digit, or two low nibbles packed
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (rd_addr == DIGIT_FIRST + ADDR_W'(i)) begin
				rd_data = {4'h0, digit_q[i][3:0]};
			end
		end
		for (int k = 0; k < PAIR_COUNT; k++) begin
			if (rd_addr == PAIR_FIRST + ADDR_W'(k)) begin
				rd_data = {digit_q[2*k+1][3:0], digit_q[2*k][3:0]};
			end
		end
	end

	assign digit = digit_q;

endmodule
`default_nettype wire

// ===== sv/subleq_cpu_with_mapped_display.sv =====
// subleq cpu top level: host command sequencer, main memory and display
//
//  channel   | signals                      | direction | handshake
//  ----------+------------------------------+-----------+------------------------------
//  command   | start, busy, command          | in        | taken when start && !busy
//  result    | done, result                 | out       | one cycle strobe on done
//  config    | cfg_wr_en, cfg_wr_data       | in        | start address, written on enable
//
// a write or start is answered from idle, a read passes through the read state, and an
// instruction step through fetch a, b, c, load a and load b: five reads and one write in turn
// through the single main memory port, with registered read data. a step while halted stays idle.
// done rises the cycle after the last of these; a new word may be taken in that
// same cycle. reset clears pc (halted), the display and the start address to 10;
// main memory is not cleared. results cannot be held off by the receiver.
`default_nettype none
module subleq_cpu_with_mapped_display import scpu_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire cmd_word_t         command,
	output logic                   done,
	output res_word_t              result,
	input  wire logic              cfg_wr_en,
	input  wire logic [ADDR_W-1:0] cfg_wr_data
);

	state_t            state_q, state_nxt;
	logic [ADDR_W-1:0] pc_q;
	logic [ADDR_W-1:0] start_addr_q;
	logic              done_q;
	logic [DATA_W-1:0] rd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] a_q, b_q, c_q;
	logic [DATA_W-1:0] ma_q;

	logic              accept;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;
	disp_wr_t          disp_wr;
	logic [DATA_W-1:0] disp_rd;
	logic [DATA_W-1:0] digit [DIGIT_COUNT];
	logic [DATA_W-1:0] bus_rd;
	logic [DATA_W-1:0] diff;
	logic              take_jump;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// data returned for the address issued last cycle
	assign bus_rd    = is_mapped(addr_q) ? disp_rd : ram_rdata;
	assign diff      = bus_rd - ma_q;
	assign take_jump = (diff == '0) || diff[DATA_W-1];

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && command.action == ACT_READ) begin
					state_nxt = ST_READ;
				end else if (accept && command.action == ACT_STEP && pc_q != '0) begin
					state_nxt = ST_FETCH_A;
				end
			end
			ST_READ:    state_nxt = ST_IDLE;
			ST_FETCH_A: state_nxt = ST_FETCH_B;
			ST_FETCH_B: state_nxt = ST_FETCH_C;
			ST_FETCH_C: state_nxt = ST_LOAD_A;
			ST_LOAD_A:  state_nxt = ST_LOAD_B;
			ST_LOAD_B:  state_nxt = ST_IDLE;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	// memory and display port drive
	always_comb begin
		ram_addr     = command.address;
		ram_we       = 1'b0;
		ram_wdata    = command.write_data;
		disp_wr.we   = 1'b0;
		disp_wr.addr = command.address;
		disp_wr.data = command.write_data;
		case (state_q)
			ST_IDLE: begin
				if (command.action == ACT_STEP) begin
					ram_addr = pc_q;
				end
				if (accept && command.action == ACT_WRITE) begin
					ram_we     = !is_mapped(command.address);
					disp_wr.we = is_mapped(command.address);
				end
			end
			ST_READ:    ram_addr = command.address;
			ST_FETCH_A: ram_addr = pc_q + ADDR_W'(1);
			ST_FETCH_B: ram_addr = pc_q + ADDR_W'(2);
			ST_FETCH_C: ram_addr = a_q;
			ST_LOAD_A:  ram_addr = b_q;
			ST_LOAD_B: begin
				ram_addr     = b_q;
				ram_wdata    = diff;
				ram_we       = !is_mapped(b_q);
				disp_wr.we   = is_mapped(b_q);
				disp_wr.addr = b_q;
				disp_wr.data = diff;
			end
			default: ram_addr = command.address;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pc_q         <= '0;
			start_addr_q <= START_RESET;
			done_q       <= 1'b0;
			rd_q         <= '0;
		end else begin
			state_q <= state_nxt;
			done_q  <= 1'b0;
			if (cfg_wr_en) begin
				start_addr_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (command.action)
							ACT_WRITE: begin
								done_q <= 1'b1;
								rd_q   <= '0;
							end
							ACT_START: begin
								pc_q   <= start_addr_q;
								done_q <= 1'b1;
								rd_q   <= '0;
							end
							ACT_STEP: begin
								if (pc_q == '0) begin
									done_q <= 1'b1;
									rd_q   <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					rd_q   <= bus_rd;
					done_q <= 1'b1;
				end
				ST_LOAD_B: begin
					pc_q   <= take_jump ? c_q : pc_q + PC_STEP;
					done_q <= 1'b1;
					rd_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	// operand registers
	always_ff @(posedge clk) begin
		addr_q <= ram_addr;
		case (state_q)
			ST_FETCH_A: a_q  <= bus_rd;
			ST_FETCH_B: b_q  <= bus_rd;
			ST_FETCH_C: c_q  <= bus_rd;
			ST_LOAD_A:  ma_q <= bus_rd;
			default: ;
		endcase
	end

	// main memory
	scpu_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// display registers
	scpu_disp u_disp (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (disp_wr),
		.rd_addr (addr_q),
		.rd_data (disp_rd),
		.digit   (digit)
	);

	// result word
	assign done                   = done_q;
	assign result.read_data       = rd_q;
	assign result.program_counter = pc_q;
	assign result.halted          = (pc_q == '0);
	assign result.digit_0         = digit[0];
	assign result.digit_1         = digit[1];
	assign result.digit_2         = digit[2];
	assign result.digit_3         = digit[3];
	assign result.digit_4         = digit[4];
	assign result.digit_5         = digit[5];

	// a result only follows a taken word or the end of a read or step
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(accept || state_q == ST_READ || state_q == ST_LOAD_B))
		else $error("result strobe without a cause");

	// memory and display are never written together
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && disp_wr.we))
		else $error("memory and display written in the same cycle");

	// main memory is never written at a display address
	a_ram_unmapped: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !is_mapped(ram_addr))
		else $error("main memory written at a display address");

	// a step completes right after its write-back cycle
	a_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD_B |=> done_q && state_q == ST_IDLE)
		else $error("step did not complete after write-back");

	// a step while halted answers at once and stays halted
	a_halted_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command.action == ACT_STEP && pc_q == '0 |=> done_q && pc_q == '0)
		else $error("step while halted changed the machine");

endmodule
`default_nettype wire
